// File: sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared codes, field widths and control types of the matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  // Fixed field widths
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Operation codes carried by func
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // Control word that travels with operands into the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } mme_mac_ctrl_t;

endpackage

`default_nettype wire

// File: sv/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// Shared multiply-accumulate unit: registered signed product, then
// registered accumulation with a done pulse on the final term.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mac #(
  parameter int DATA_WIDTH = 16,
  parameter int PROD_W = 35
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mme_pkg::mme_mac_ctrl_t    ctrl,
  input  wire logic [DATA_WIDTH-1:0]     a,
  input  wire logic [DATA_WIDTH-1:0]     b,
  output logic signed [PROD_W-1:0]       acc,
  output logic                           done
);
  import mme_pkg::*;

  mme_mac_ctrl_t                 ctrl_p;
  logic signed [2*DATA_WIDTH-1:0] prod;

  // Stage 1: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_p <= '0;
    end else begin
      ctrl_p <= ctrl;
    end
    prod <= $signed(a) * $signed(b);
  end

  // Stage 2: accumulate, restart on the first term
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_p.valid && ctrl_p.lastk;
    end
    if (ctrl_p.valid) begin
      if (ctrl_p.first) begin
        acc <= PROD_W'(prod);
      end else begin
        acc <= acc + PROD_W'(prod);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/matrix_multiply_engine_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// Dense matrix product C = A x B in signed fixed point, exact Q19.16 sums.
// ----------------------------------------------------------------------------
// Load words (func load A / load B) write one element at (row, col), and
// loads stream at one per cycle while the block is idle; a load whose row
// or col is not below MAX_DIM is dropped, as is func code 3. A compute word
// emits every element of C in row-major order, each with its row, its
// column and a last flag. The block works through C one element at a time
// on a single shared multiply-accumulate unit fed by the two element RAMs:
// for each element, the terms of the inner dimension pass through the RAM
// read, multiply and accumulate registers, and the sum is then placed in
// the output register once that register is free, so output stalls slow
// the compute. in_stall is high for the whole compute; loads are taken
// again as soon as the final element sits in the output register.
// Dimension registers read as 1 when zero and as MAX_DIM when above it.
// Configuration words are always accepted and must be sent only while the
// block is idle. Reading an element of A or B that was never written gives
// an undefined result.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine_top #(
  parameter int MAX_DIM = 8,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration write channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [mme_pkg::CFG_W-1:0]              cfg_data,
  // input word channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [mme_pkg::FUNC_W-1:0]             func,
  input  wire logic [mme_pkg::IDX_W-1:0]              row,
  input  wire logic [mme_pkg::IDX_W-1:0]              col,
  input  wire logic signed [DATA_WIDTH-1:0]           value,
  // result word channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [2*DATA_WIDTH+2:0]              product,
  output logic [mme_pkg::IDX_W-1:0]                   out_row,
  output logic [mme_pkg::IDX_W-1:0]                   out_col,
  output logic                                        last
);
  import mme_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * DATA_WIDTH + 3;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_PUT} state_t;

  state_t              state;
  logic [CFG_W-1:0]    rows_a, inner_dim, cols_b;
  logic [CFG_W-1:0]    dim_m, dim_n, dim_p;
  logic [IDX_W-1:0]    cnt_i, cnt_j, cnt_k;

  logic                load_ok, we_a, we_b;
  logic [ADDR_W-1:0]   waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;

  mme_mac_ctrl_t       issue, issue_d;
  logic signed [PROD_W-1:0] acc;
  logic                mac_done;
  logic                k_last, j_last, i_last, out_free;

  // Clamp a dimension register into 1..MAX_DIM
  function automatic logic [CFG_W-1:0] dim_clamp(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] d;
    priority if (r == '0) begin
      d = CFG_W'(1);
    end else if (32'(r) > MAX_DIM) begin
      d = CFG_W'(MAX_DIM);
    end else begin
      d = r;
    end
    return d;
  endfunction

  // Configuration registers; a write beyond the list is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(8);
      inner_dim <= CFG_W'(8);
      cols_b    <= CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load path: write port of both element RAMs, used only while idle
  assign in_stall = (state != S_IDLE);
  assign load_ok  = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
  assign we_a     = in_valid && !in_stall && (func == FUNC_LOAD_A) && load_ok;
  assign we_b     = in_valid && !in_stall && (func == FUNC_LOAD_B) && load_ok;
  assign waddr    = ADDR_W'(32'(row) * MAX_DIM + 32'(col));

  // Read addresses follow the loop counters: A[i][k] and B[k][j]
  assign raddr_a = ADDR_W'(32'(cnt_i) * MAX_DIM + 32'(cnt_k));
  assign raddr_b = ADDR_W'(32'(cnt_k) * MAX_DIM + 32'(cnt_j));

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Loop end tests against the clamped dimensions
  assign k_last   = ({1'b0, cnt_k} == dim_n - CFG_W'(1));
  assign j_last   = ({1'b0, cnt_j} == dim_p - CFG_W'(1));
  assign i_last   = ({1'b0, cnt_i} == dim_m - CFG_W'(1));
  assign out_free = !out_valid || !out_stall;

  // One inner-dimension term issued per RUN cycle
  always_comb begin
    issue.valid = (state == S_RUN);
    issue.first = (cnt_k == '0);
    issue.lastk = k_last;
  end

  // Register the control word to line up with the registered RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_d <= '0;
    end else begin
      issue_d <= issue;
    end
  end

  mme_mac #(.DATA_WIDTH(DATA_WIDTH), .PROD_W(PROD_W)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (issue_d),
    .a    (rdata_a),
    .b    (rdata_b),
    .acc  (acc),
    .done (mac_done)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt_i     <= '0;
      cnt_j     <= '0;
      cnt_k     <= '0;
    end else begin
      // drop the result word once it is taken; in S_PUT the next word replaces it
      if (out_valid && !out_stall && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // latch clamped dimensions and start at element (0, 0)
          if (in_valid && (func == FUNC_COMPUTE)) begin
            dim_m <= dim_clamp(rows_a);
            dim_n <= dim_clamp(inner_dim);
            dim_p <= dim_clamp(cols_b);
            cnt_i <= '0;
            cnt_j <= '0;
            cnt_k <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          // advance over the inner dimension
          if (k_last) begin
            cnt_k <= '0;
            state <= S_DRAIN;
          end else begin
            cnt_k <= cnt_k + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // wait for the final term to leave the accumulator
          if (mac_done) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          // hold the sum until the output register frees up
          if (out_free) begin
            out_valid <= 1'b1;
            product   <= acc;
            out_row   <= cnt_i;
            out_col   <= cnt_j;
            last      <= i_last && j_last;
            if (j_last) begin
              cnt_j <= '0;
              if (i_last) begin
                state <= S_IDLE;
              end else begin
                cnt_i <= cnt_i + IDX_W'(1);
                state <= S_RUN;
              end
            end else begin
              cnt_j <= cnt_j + IDX_W'(1);
              state <= S_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_checker #(
  parameter int PROD_W = 35
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [mme_pkg::FUNC_W-1:0]       func,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [PROD_W-1:0]                product,
  input wire logic                             last
);
  import mme_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product) && $stable(last))
    else $error("result word changed while stalled");

  // A compute word makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FUNC_COMPUTE) |=> in_stall)
    else $error("block not busy after compute word");

  // While idle, only the final element can still be pending
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    !in_stall && out_valid |-> last)
    else $error("idle with a non-final result pending");

  // While idle, nothing follows the final element directly
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last && !in_stall |=> !out_valid)
    else $error("result word right after the final element");

endmodule

bind matrix_multiply_engine_top mme_checker #(.PROD_W(PROD_W)) u_mme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .product   (product),
  .last      (last)
);

`default_nettype wire
